### hw/rtl/bpc_pkg.sv
// Shared types and codes for the box push-out collider.
// Depends on nothing; the collider top level and its checker import it.
`default_nettype none

package bpc_pkg;

   // Function codes carried by the request word.
   typedef enum logic [1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_PUSH  = 2'd1,
      FUNC_TEST  = 2'd2
   } func_type;

   // Configuration register indexes.
   localparam logic [1:0] CSR_BOX_HEIGHT  = 2'd0;
   localparam logic [1:0] CSR_PUSH_MARGIN = 2'd1;
   localparam logic [1:0] CSR_ACTIVE_AREA = 2'd2;

   localparam int unsigned CSR_DATA_W = 12;

   localparam logic [11:0] BOX_HEIGHT_RST  = 12'd900;
   localparam logic [9:0]  PUSH_MARGIN_RST = 10'd0;
   localparam logic [7:0]  ACTIVE_AREA_RST = 8'd0;

   // One table entry as held in the box memory.
   typedef struct packed {
      logic signed [15:0] cx;
      logic signed [15:0] cz;
      logic signed [15:0] foot;
      logic [11:0]        hx;
      logic [11:0]        hz;
      logic [7:0]         area;
      logic               solid;
   } box_entry_type;

endpackage

`default_nettype wire

### hw/rtl/box_pushout_collider.sv
// Box push-out collider top level: box table memory, query sequencer and datapath.
// Depends on bpc_pkg for function codes, register indexes and the entry type.
//
// Usage:
//   The request channel (req_*) carries one word per operation. FUNC_WRITE stores
//   a box into slot req_box_index (ignored at or beyond MAX_BOXES) and returns
//   nothing. FUNC_PUSH pushes the point out of every taking-part box grown by
//   req_reach plus push_margin; FUNC_TEST checks the point against boxes grown by
//   req_reach, bounds included. Each query returns one rsp_* word. Code 3 is
//   dropped without a response.
//   The csr_* port writes box_height, push_margin and active_area; write it only
//   while no query is in flight.
//   Flow: a query holds req_stall high while the sequencer walks the table,
//   one slot read per cycle from the box memory, then through a bounds stage
//   and an update stage; the update stage is the only place that depends on the
//   position moved by the previous box.
//   Reset clears all slot valid bits and restores register defaults; memory
//   contents stay as they are but are never used until rewritten.
//   A stalled response holds in its output register; the next request is taken
//   meanwhile, and a query that finishes while the output is still full waits
//   in place with req_stall high until the word is taken.
`default_nettype none

module box_pushout_collider #(
   parameter int unsigned MAX_BOXES = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [1:0]            req_func,
   input  wire logic [2:0]            req_box_index,
   input  wire logic signed [15:0]    req_pos_x,
   input  wire logic signed [15:0]    req_pos_y,
   input  wire logic signed [15:0]    req_pos_z,
   input  wire logic [11:0]           req_half_width_x,
   input  wire logic [11:0]           req_half_width_z,
   input  wire logic [7:0]            req_area_tag,
   input  wire logic                  req_solid_flag,
   input  wire logic [11:0]           req_reach,
   // response channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic signed [15:0]         rsp_out_x,
   output logic signed [15:0]         rsp_out_z,
   output logic                       rsp_inside_solid,
   // configuration port
   input  wire logic                  csr_wr_en,
   input  wire logic [1:0]            csr_index,
   input  wire logic [bpc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bpc_pkg::*;

   localparam int unsigned IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_BOXES + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_HOLD
   } state_type;

   // Clamp an 18-bit signed position to the 16-bit range.
   function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
      logic signed [15:0] r;
      if (v > 18'sd32767) r = 16'sh7fff;
      else if (v < -18'sd32768) r = 16'sh8000;
      else r = v[15:0];
      return r;
   endfunction

   // ---------------- configuration registers ----------------
   logic [11:0] box_height_ff;
   logic [9:0]  push_margin_ff;
   logic [7:0]  active_area_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_height_ff  <= BOX_HEIGHT_RST;
         push_margin_ff <= PUSH_MARGIN_RST;
         active_area_ff <= ACTIVE_AREA_RST;
      end else if (csr_wr_en) begin
         // out-of-range indexes fall through and change nothing
         if (csr_index == CSR_BOX_HEIGHT) box_height_ff <= csr_wdata[11:0];
         if (csr_index == CSR_PUSH_MARGIN) push_margin_ff <= csr_wdata[9:0];
         if (csr_index == CSR_ACTIVE_AREA) active_area_ff <= csr_wdata[7:0];
      end
   end

   // ---------------- request decode ----------------
   state_type state_ff;
   logic      req_accept;
   logic      wr_fire;
   logic      query_fire;
   logic [6:0] wr_idx_wide;

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign wr_idx_wide = 7'(req_box_index);
   assign wr_fire     = req_accept && (req_func == FUNC_WRITE) &&
                        (wr_idx_wide < 7'(MAX_BOXES));
   assign query_fire  = req_accept && ((req_func == FUNC_PUSH) || (req_func == FUNC_TEST));

   // ---------------- box memory and valid bits ----------------
   box_entry_type            box_mem [MAX_BOXES];
   logic [MAX_BOXES-1:0]     slot_valid_ff;
   box_entry_type            wr_entry;
   box_entry_type            rd_entry_ff;
   logic                     rd_slot_valid_ff;
   logic [CNT_W-1:0]         issue_cnt_ff;
   logic                     issue_go;
   logic [IDX_W-1:0]         rd_addr;
   logic                     s1_vld_ff;

   assign wr_entry.cx    = req_pos_x;
   assign wr_entry.cz    = req_pos_z;
   assign wr_entry.foot  = req_pos_y;
   assign wr_entry.hx    = req_half_width_x;
   assign wr_entry.hz    = req_half_width_z;
   assign wr_entry.area  = req_area_tag;
   assign wr_entry.solid = req_solid_flag;

   assign issue_go = (state_ff == ST_RUN) && (issue_cnt_ff != CNT_W'(MAX_BOXES));
   assign rd_addr  = issue_cnt_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_fire) box_mem[wr_idx_wide[IDX_W-1:0]] <= wr_entry;
      if (issue_go) begin
         rd_entry_ff      <= box_mem[rd_addr];
         rd_slot_valid_ff <= slot_valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
      end else if (wr_fire) begin
         slot_valid_ff[wr_idx_wide[IDX_W-1:0]] <= 1'b1;
      end
   end

   // ---------------- query context ----------------
   logic signed [15:0] x_ff, z_ff, y_ff;
   logic [12:0]        grow_ff;
   logic               push_mode_ff;
   logic               hit_ff;

   // ---------------- issue counter and stage valids ----------------
   logic s2_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_cnt_ff <= '0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
      end else begin
         if (query_fire) issue_cnt_ff <= '0;
         else if (issue_go) issue_cnt_ff <= issue_cnt_ff + CNT_W'(1);
         s1_vld_ff <= issue_go;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   // ---------------- bounds stage: independent of the moving point ----------------
   logic signed [17:0] e_cx, e_cz, e_foot, e_hx, e_hz, e_grow, e_y, foot_lo;
   logic               part_in;
   logic signed [17:0] min_x_ff, max_x_ff, min_z_ff, max_z_ff;
   logic               part_ff;

   assign e_cx    = {{2{rd_entry_ff.cx[15]}}, rd_entry_ff.cx};
   assign e_cz    = {{2{rd_entry_ff.cz[15]}}, rd_entry_ff.cz};
   assign e_foot  = {{2{rd_entry_ff.foot[15]}}, rd_entry_ff.foot};
   assign e_hx    = {6'b0, rd_entry_ff.hx};
   assign e_hz    = {6'b0, rd_entry_ff.hz};
   assign e_grow  = {5'b0, grow_ff};
   assign e_y     = {{2{y_ff[15]}}, y_ff};
   assign foot_lo = e_foot - {6'b0, box_height_ff};
   assign part_in = rd_slot_valid_ff && rd_entry_ff.solid &&
                    (rd_entry_ff.area == active_area_ff) &&
                    (e_y <= e_foot) && (e_y >= foot_lo);

   always_ff @(posedge clock) begin
      if (s1_vld_ff) begin
         min_x_ff <= e_cx - e_hx - e_grow;
         max_x_ff <= e_cx + e_hx + e_grow;
         min_z_ff <= e_cz - e_hz - e_grow;
         max_z_ff <= e_cz + e_hz + e_grow;
         part_ff  <= part_in;
      end
   end

   // ---------------- update stage: penetration and push ----------------
   logic signed [17:0] x18, z18, pl, pr, pf, pb, best, dx, dz;
   logic               push_hit, test_hit;
   logic signed [15:0] x_new, z_new;

   assign x18 = {{2{x_ff[15]}}, x_ff};
   assign z18 = {{2{z_ff[15]}}, z_ff};
   assign pl  = x18 - min_x_ff;
   assign pr  = max_x_ff - x18;
   assign pf  = z18 - min_z_ff;
   assign pb  = max_z_ff - z18;
   assign push_hit = (pl > 18'sd0) && (pr > 18'sd0) && (pf > 18'sd0) && (pb > 18'sd0);
   assign test_hit = (pl >= 18'sd0) && (pr >= 18'sd0) && (pf >= 18'sd0) && (pb >= 18'sd0);

   // Smallest penetration wins; on a tie keep the earlier of left, right, front, back.
   always_comb begin
      best = pl;
      dx   = -pl;
      dz   = 18'sd0;
      if (pr < best) begin
         best = pr;
         dx   = pr;
         dz   = 18'sd0;
      end
      if (pf < best) begin
         best = pf;
         dx   = 18'sd0;
         dz   = -pf;
      end
      if (pb < best) begin
         dx = 18'sd0;
         dz = pb;
      end
   end

   assign x_new = sat16(x18 + dx);
   assign z_new = sat16(z18 + dz);

   always_ff @(posedge clock) begin
      if (query_fire) begin
         // latch the query; func 2 grows by req_reach alone
         x_ff         <= req_pos_x;
         y_ff         <= req_pos_y;
         z_ff         <= req_pos_z;
         push_mode_ff <= (req_func == FUNC_PUSH);
         grow_ff      <= (req_func == FUNC_PUSH) ?
                         (13'(req_reach) + 13'(push_margin_ff)) : 13'(req_reach);
         hit_ff       <= 1'b0;
      end else if (s2_vld_ff && part_ff) begin
         if (push_mode_ff) begin
            if (push_hit) begin
               x_ff   <= x_new;
               z_ff   <= z_new;
               hit_ff <= 1'b1;
            end
         end else if (test_hit) begin
            hit_ff <= 1'b1;
         end
      end
   end

   // ---------------- sequencer and response register ----------------
   logic               walk_done;
   logic               out_free;
   logic               rsp_load;
   logic               rsp_valid_ff;
   logic signed [15:0] rsp_out_x_ff;
   logic signed [15:0] rsp_out_z_ff;
   logic               rsp_inside_solid_ff;

   assign walk_done = (issue_cnt_ff == CNT_W'(MAX_BOXES)) && !s1_vld_ff && !s2_vld_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_load  = (state_ff != ST_IDLE) && walk_done && out_free;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_x        = rsp_out_x_ff;
   assign rsp_out_z        = rsp_out_z_ff;
   assign rsp_inside_solid = rsp_inside_solid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // load a finished query, else drop a word once it is taken
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (query_fire) state_ff <= ST_RUN;
            end
            ST_RUN, ST_HOLD: begin
               // hold the result until the output register is free
               if ((state_ff == ST_HOLD) || walk_done) begin
                  if (out_free) begin
                     rsp_out_x_ff        <= x_ff;
                     rsp_out_z_ff        <= z_ff;
                     rsp_inside_solid_ff <= hit_ff;
                     state_ff            <= ST_IDLE;
                  end else begin
                     state_ff <= ST_HOLD;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

### hw/rtl/bpc_checker.sv
// Port-level checker for the box push-out collider, bound to its top level.
// Depends on bpc_pkg for the function codes and on box_pushout_collider's ports.
`default_nettype none

module bpc_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic [1:0]         req_func,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic signed [15:0] rsp_out_x,
   input wire logic signed [15:0] rsp_out_z,
   input wire logic               rsp_inside_solid
);
   import bpc_pkg::*;

   logic req_take;
   logic query_take;

   assign req_take   = req_valid && !req_stall;
   assign query_take = req_take && ((req_func == FUNC_PUSH) || (req_func == FUNC_TEST));

   // A stalled response word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_x) &&
                                 $stable(rsp_out_z) && $stable(rsp_inside_solid))
      else $error("response word changed while stalled");

   // Reset drops any pending response.
   a_reset_clear: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A table write never produces a response word.
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_take && (req_func == FUNC_WRITE) && !rsp_valid |=> !rsp_valid)
      else $error("response after a table write");

   // A query blocks the request side and needs the table walk before answering.
   a_query_walk: assert property (@(posedge clock) disable iff (reset)
      query_take && !rsp_valid |=> req_stall && !rsp_valid ##1 !rsp_valid)
      else $error("query answered too early or request side not stalled");

endmodule

bind box_pushout_collider bpc_checker u_bpc_checker (.*);

`default_nettype wire
